FILE: rtl/chunked_event_line_deframer_assert.svh
// Assertion macros used by the checker file.
`ifndef CHUNKED_EVENT_LINE_DEFRAMER_ASSERT_SVH
`define CHUNKED_EVENT_LINE_DEFRAMER_ASSERT_SVH

// Checked at every clock edge while reset is released.
`define CELD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CELD_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/celd_pkg.sv
package celd_pkg;

	localparam int SIZE_LINE_CHARS = 19;
	localparam int CHUNK_SIZE_BITS = 32;
	localparam int SIZE_CNT_W      = $clog2(SIZE_LINE_CHARS + 1);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int MAX_RES    = 2;

	localparam logic REG_CHUNKED_MODE = 1'b0;
	localparam logic REG_RAW_MODE     = 1'b1;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	localparam logic [2:0] LP_START      = 3'd0;
	localparam logic [2:0] LP_WAIT_SPACE = 3'd5;
	localparam logic [2:0] LP_BODY       = 3'd6;
	localparam logic [2:0] LP_REJECT     = 3'd7;

	typedef enum logic [1:0] {
		RK_BYTE = 2'd0,
		RK_END  = 2'd1,
		RK_DROP = 2'd2
	} result_kind_t;

	typedef enum logic [3:0] {
		CP_SIZE = 4'b0001,
		CP_DATA = 4'b0010,
		CP_CRLF = 4'b0100,
		CP_DONE = 4'b1000
	} chunk_phase_t;

	typedef enum logic [3:0] {
		SP_START  = 4'b0001,
		SP_ZERO   = 4'b0010,
		SP_DIGITS = 4'b0100,
		SP_STOP   = 4'b1000
	} size_phase_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   data;
		logic         last;
	} res_t;

	typedef struct packed {
		logic [2:0] ph;
		logic       report;
	} lc_t;

	function automatic logic [7:0] prefix_char(logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h64;
			3'd1: c = 8'h61;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Returns the hex digit value with a valid flag in the top bit.
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// One content byte through the data: prefix tracker.
	function automatic lc_t line_step(logic [2:0] ph, logic [7:0] c, logic raw);
		lc_t r;
		r.ph     = ph;
		r.report = raw;
		if (ph < LP_WAIT_SPACE) begin
			r.ph = (c == prefix_char(ph)) ? ph + 3'd1 : LP_REJECT;
		end else if (ph == LP_WAIT_SPACE) begin
			r.ph     = LP_BODY;
			r.report = raw || (c != CH_SPACE);
		end else if (ph == LP_BODY) begin
			r.report = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: rtl/celd_in_if.sv
interface celd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] body_byte;

	modport source (output valid, output kind, output body_byte, input ready);
	modport sink (input valid, input kind, input body_byte, output ready);
endinterface

FILE: rtl/celd_out_if.sv
interface celd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] line_byte;
	logic       last_of_item;

	modport source (output valid, output result_kind, output line_byte, output last_of_item,
		input ready);
	modport sink (input valid, input result_kind, input line_byte, input last_of_item,
		output ready);
endinterface

FILE: rtl/chunked_event_line_deframer.sv
// Body bytes are taken one per clock while input ready is high: each accepted transaction is
// registered, decoded in the next cycle against the framing and line state, and its zero to
// two results are written into an eight-entry result queue. Input ready stays high while the
// queue can absorb two results for the byte in decode and two for a new one; the output side
// drains one result per cycle while output ready is high, so a stream of bytes that each give
// one result or none runs at one byte per cycle unless the output stalls, and a byte that gives
// two results (a held CR released together with the next byte, or a flush) takes two entries.
module chunked_event_line_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       write_en,
	input  logic       reg_index,
	input  logic       write_data,
	celd_in_if.sink    items,
	celd_out_if.source results
);
	import celd_pkg::*;

	logic chunked_q;
	logic raw_q;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	chunk_phase_t               chunk_q, chunk_n;
	logic [SIZE_CNT_W-1:0]      scnt_q, scnt_n;
	size_phase_t                sphase_q, sphase_n;
	logic [CHUNK_SIZE_BITS-1:0] sval_q, sval_n;
	logic [CHUNK_SIZE_BITS-1:0] rem_q, rem_n, rem_dec;
	logic [2:0]                 lphase_q, lphase_n;
	logic                       pcr_q, pcr_n;
	logic                       ne_q, ne_n;

	res_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q, tail_q;
	logic [FIFO_CW-1:0] cnt_q;

	lc_t        lc_cr, lc_byte;
	logic [4:0] hex;
	logic [CHUNK_SIZE_BITS-1:0] acc;

	logic [2:0] pl_ph;
	logic       pl_cr, pl_ne;
	logic [1:0] pl_n;
	res_t       pl_res [MAX_RES];

	logic [1:0] n;
	res_t       res [MAX_RES];
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_q <= 1'b0;
			raw_q     <= 1'b0;
		end else if (write_en) begin
			case (reg_index)
				REG_CHUNKED_MODE: chunked_q <= write_data;
				REG_RAW_MODE:     raw_q     <= write_data;
				default: ;
			endcase
		end
	end

	assign items.ready = ({1'b0, cnt_q} + (valid_s1 ? (FIFO_CW+1)'(MAX_RES) : '0))
		<= (FIFO_CW+1)'(FIFO_DEPTH - MAX_RES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= items.valid && items.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			kind_s1 <= items.kind;
			byte_s1 <= items.body_byte;
		end
	end

	assign lc_cr   = line_step(lphase_q, CH_CR, raw_q);
	assign lc_byte = line_step(pcr_q ? lc_cr.ph : lphase_q, byte_s1, raw_q);
	assign hex     = hex_val(byte_s1);
	assign acc     = (|sval_q[CHUNK_SIZE_BITS-1 -: 4]) ? '1
		: {sval_q[CHUNK_SIZE_BITS-5:0], hex[3:0]};
	assign rem_dec = (rem_q != '0) ? rem_q - CHUNK_SIZE_BITS'(1) : rem_q;

	// Payload byte through the line splitter.
	always_comb begin
		pl_ph  = lphase_q;
		pl_cr  = pcr_q;
		pl_ne  = ne_q;
		pl_n   = 2'd0;
		pl_res = '{default: '0};
		if (byte_s1 == CH_LF) begin
			if (raw_q ? ne_q : (lphase_q inside {LP_WAIT_SPACE, LP_BODY})) begin
				pl_res[0].kind = RK_END;
				pl_n = 2'd1;
			end
			pl_ph = LP_START;
			pl_cr = 1'b0;
			pl_ne = 1'b0;
		end else begin
			if (pcr_q) begin
				pl_cr = 1'b0;
				pl_ne = 1'b1;
				pl_ph = lc_cr.ph;
				if (lc_cr.report) begin
					pl_res[0].kind = RK_BYTE;
					pl_res[0].data = CH_CR;
					pl_n = 2'd1;
				end
			end
			if (byte_s1 == CH_CR) begin
				pl_cr = 1'b1;
			end else begin
				pl_ne = 1'b1;
				pl_ph = lc_byte.ph;
				if (lc_byte.report) begin
					pl_res[pl_n[0]].kind = RK_BYTE;
					pl_res[pl_n[0]].data = byte_s1;
					pl_n = pl_n + 2'd1;
				end
			end
		end
	end

	always_comb begin
		chunk_n  = chunk_q;
		scnt_n   = scnt_q;
		sphase_n = sphase_q;
		sval_n   = sval_q;
		rem_n    = rem_q;
		lphase_n = lphase_q;
		pcr_n    = pcr_q;
		ne_n     = ne_q;
		n        = 2'd0;
		res      = '{default: '0};
		if (valid_s1) begin
			if (kind_s1 == KIND_FLUSH) begin
				if (raw_q) begin
					if (ne_q || pcr_q) begin
						if (pcr_q) begin
							res[0].kind = RK_BYTE;
							res[0].data = CH_CR;
							n = 2'd1;
						end
						res[n[0]].kind = RK_END;
						n = n + 2'd1;
					end
				end else if (lphase_q inside {LP_WAIT_SPACE, LP_BODY}) begin
					res[0].kind = RK_DROP;
					n = 2'd1;
				end
				lphase_n = LP_START;
				pcr_n    = 1'b0;
				ne_n     = 1'b0;
				chunk_n  = CP_SIZE;
				scnt_n   = '0;
				sphase_n = SP_START;
				sval_n   = '0;
				rem_n    = '0;
			end else if (!chunked_q) begin
				lphase_n = pl_ph;
				pcr_n    = pl_cr;
				ne_n     = pl_ne;
				n        = pl_n;
				res      = pl_res;
			end else begin
				case (chunk_q)
					CP_SIZE: begin
						if (byte_s1 == CH_LF) begin
							rem_n    = sval_q;
							chunk_n  = (sval_q != '0) ? CP_DATA : CP_DONE;
							sval_n   = '0;
							scnt_n   = '0;
							sphase_n = SP_START;
						end else if (byte_s1 != CH_CR
							&& scnt_q < SIZE_CNT_W'(SIZE_LINE_CHARS)) begin
							scnt_n = scnt_q + SIZE_CNT_W'(1);
							case (sphase_q)
								SP_START: begin
									if (byte_s1 inside {CH_SPACE, CH_TAB, CH_VT, CH_FF}) begin
										sphase_n = SP_START;
									end else if (byte_s1 == CH_ZERO) begin
										sval_n   = '0;
										sphase_n = SP_ZERO;
									end else if (hex[4]) begin
										sval_n   = CHUNK_SIZE_BITS'(hex[3:0]);
										sphase_n = SP_DIGITS;
									end else begin
										sphase_n = SP_STOP;
									end
								end
								SP_ZERO: begin
									if (byte_s1 == CH_LOW_X || byte_s1 == CH_UP_X) begin
										sphase_n = SP_DIGITS;
									end else if (hex[4]) begin
										sval_n   = acc;
										sphase_n = SP_DIGITS;
									end else begin
										sphase_n = SP_STOP;
									end
								end
								SP_DIGITS: begin
									if (hex[4]) begin
										sval_n = acc;
									end else begin
										sphase_n = SP_STOP;
									end
								end
								default: ;
							endcase
						end
					end
					CP_DATA: begin
						lphase_n = pl_ph;
						pcr_n    = pl_cr;
						ne_n     = pl_ne;
						n        = pl_n;
						res      = pl_res;
						rem_n    = rem_dec;
						if (rem_dec == '0) begin
							chunk_n = CP_CRLF;
						end
					end
					CP_CRLF: begin
						if (byte_s1 == CH_LF) begin
							chunk_n = CP_SIZE;
						end
					end
					default: ;
				endcase
			end
		end
		if (n == 2'd1) begin
			res[0].last = 1'b1;
		end else if (n == 2'd2) begin
			res[1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q  <= CP_SIZE;
			scnt_q   <= '0;
			sphase_q <= SP_START;
			sval_q   <= '0;
			rem_q    <= '0;
			lphase_q <= LP_START;
			pcr_q    <= 1'b0;
			ne_q     <= 1'b0;
		end else begin
			chunk_q  <= chunk_n;
			scnt_q   <= scnt_n;
			sphase_q <= sphase_n;
			sval_q   <= sval_n;
			rem_q    <= rem_n;
			lphase_q <= lphase_n;
			pcr_q    <= pcr_n;
			ne_q     <= ne_n;
		end
	end

	assign pop = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			head_q <= head_q + FIFO_AW'(pop);
			tail_q <= tail_q + FIFO_AW'(n);
			cnt_q  <= cnt_q + FIFO_CW'(n) - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n != 2'd0) begin
			fifo_q[tail_q] <= res[0];
		end
		if (n == 2'd2) begin
			fifo_q[tail_q + FIFO_AW'(1)] <= res[1];
		end
	end

	assign results.valid        = cnt_q != '0;
	assign results.result_kind  = fifo_q[head_q].kind;
	assign results.line_byte    = fifo_q[head_q].data;
	assign results.last_of_item = fifo_q[head_q].last;

endmodule

FILE: rtl/celd_checker.sv
`include "chunked_event_line_deframer_assert.svh"

module celd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] result_kind,
	input logic [7:0] line_byte,
	input logic       last_of_item
);
	import celd_pkg::*;

	`CELD_ASSERT_ANY(a_no_result_in_reset, !arst_n |-> !out_valid, "Result offered during reset.")
	`CELD_ASSERT_RST(a_kind_legal, out_valid |-> result_kind != 2'd3, "Undefined result kind.")
	`CELD_ASSERT_RST(a_marker_closes_item, out_valid && result_kind != RK_BYTE |-> last_of_item && line_byte == 8'h00, "Marker is not the clean last result of its transaction.")
	`CELD_ASSERT_RST(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(line_byte) && $stable(last_of_item), "Stalled result changed.")

endmodule

bind chunked_event_line_deframer celd_checker u_celd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.result_kind  (results.result_kind),
	.line_byte    (results.line_byte),
	.last_of_item (results.last_of_item)
);

FILE: tb/chunked_event_line_deframer_test.sv
module chunked_event_line_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import celd_pkg::*;

	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [39:0] DATA_PREFIX = "data:";

	typedef struct {
		result_kind_t kind;
		logic [7:0]   data;
		logic         last;
	} line_result_t;

	logic clk        = 1'b0;
	logic arst_n;
	logic write_en   = 1'b0;
	logic reg_index  = 1'b0;
	logic write_data = 1'b0;

	celd_in_if  in_ch();
	celd_out_if out_ch();

	chunked_event_line_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.items      (in_ch),
		.results    (out_ch)
	);

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int errors        = 0;
	int items_sent    = 0;
	int flushes_sent  = 0;
	int results_seen  = 0;
	int idle_cycles   = 0;

	line_result_t expected_results[$];
	line_result_t item_results[$];
	logic [8:0]   tx_queue[$];
	logic [7:0]   body_q[$];

	logic         mode_chunked;
	logic         mode_raw;
	chunk_phase_t chunk_state;
	size_phase_t  size_state;
	int           size_chars;
	logic [31:0]  size_acc;
	logic [31:0]  chunk_left;
	logic [2:0]   line_state;
	logic         cr_held;
	logic         line_seen;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind %0d byte 0x%02h last %0b, expected none",
					$time, out_ch.result_kind, out_ch.line_byte, out_ch.last_of_item);
			end else begin
				want = expected_results.pop_front();
				if (out_ch.result_kind !== want.kind || out_ch.line_byte !== want.data ||
						out_ch.last_of_item !== want.last) begin
					errors++;
					$display("%0t: expected kind %0d byte 0x%02h last %0b, got %0d 0x%02h %0b",
						$time, want.kind, want.data, want.last,
						out_ch.result_kind, out_ch.line_byte, out_ch.last_of_item);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || write_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, IDLE_LIMIT, expected_results.size());
			$display("chunked_event_line_deframer_test: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic void add_result(result_kind_t k, logic [7:0] b);
		line_result_t r;
		r = '{k, b, 1'b0};
		item_results.push_back(r);
	endfunction

	function automatic void clear_line();
		line_state = LP_START;
		cr_held    = 1'b0;
		line_seen  = 1'b0;
	endfunction

	function automatic void clear_framing();
		chunk_state = CP_SIZE;
		size_chars  = 0;
		size_state  = SP_START;
		size_acc    = '0;
		chunk_left  = '0;
	endfunction

	function automatic int hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void size_shift_in(int d);
		if (size_acc > 32'h0FFF_FFFF) begin
			size_acc = '1;
		end else begin
			size_acc = {size_acc[27:0], 4'(d)};
		end
	endfunction

	function automatic void take_size_char(logic [7:0] c);
		int d;
		d = hex_value(c);
		case (size_state)
			SP_START: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
				end else if (c == CH_ZERO) begin
					size_acc   = '0;
					size_state = SP_ZERO;
				end else if (d >= 0) begin
					size_acc   = 32'(d);
					size_state = SP_DIGITS;
				end else begin
					size_state = SP_STOP;
				end
			end
			SP_ZERO: begin
				if (c == CH_LOW_X || c == CH_UP_X) begin
					size_state = SP_DIGITS;
				end else if (d >= 0) begin
					size_shift_in(d);
					size_state = SP_DIGITS;
				end else begin
					size_state = SP_STOP;
				end
			end
			SP_DIGITS: begin
				if (d >= 0) size_shift_in(d);
				else size_state = SP_STOP;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void take_line_char(logic [7:0] c);
		logic shown;
		shown     = 1'b0;
		line_seen = 1'b1;
		if (line_state < LP_WAIT_SPACE) begin
			line_state = (c == DATA_PREFIX[39 - 8 * int'(line_state) -: 8]) ?
				line_state + 3'd1 : LP_REJECT;
		end else if (line_state == LP_WAIT_SPACE) begin
			line_state = LP_BODY;
			shown      = (c != CH_SPACE);
		end else if (line_state == LP_BODY) begin
			shown = 1'b1;
		end
		if (mode_raw || shown) add_result(RK_BYTE, c);
	endfunction

	function automatic void take_payload(logic [7:0] c);
		logic closes;
		if (c == CH_LF) begin
			closes = mode_raw ? line_seen : (line_state == LP_WAIT_SPACE || line_state == LP_BODY);
			if (closes) add_result(RK_END, 8'h00);
			clear_line();
		end else begin
			if (cr_held) begin
				cr_held = 1'b0;
				take_line_char(CH_CR);
			end
			if (c == CH_CR) cr_held = 1'b1;
			else take_line_char(c);
		end
	endfunction

	function automatic void predict_item(logic k, logic [7:0] b);
		item_results.delete();
		if (k == KIND_FLUSH) begin
			if (mode_raw) begin
				if (line_seen || cr_held) begin
					if (cr_held) add_result(RK_BYTE, CH_CR);
					add_result(RK_END, 8'h00);
				end
			end else if (line_state == LP_WAIT_SPACE || line_state == LP_BODY) begin
				add_result(RK_DROP, 8'h00);
			end
			clear_line();
			clear_framing();
		end else if (!mode_chunked) begin
			take_payload(b);
		end else begin
			case (chunk_state)
				CP_SIZE: begin
					if (b == CH_LF) begin
						chunk_left  = size_acc;
						chunk_state = (size_acc != 0) ? CP_DATA : CP_DONE;
						size_acc    = '0;
						size_chars  = 0;
						size_state  = SP_START;
					end else if (b != CH_CR && size_chars < SIZE_LINE_CHARS) begin
						size_chars++;
						take_size_char(b);
					end
				end
				CP_DATA: begin
					take_payload(b);
					if (chunk_left != 0) chunk_left--;
					if (chunk_left == 0) chunk_state = CP_CRLF;
				end
				CP_CRLF: begin
					if (b == CH_LF) chunk_state = CP_SIZE;
				end
				default: begin
				end
			endcase
		end
		if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
		foreach (item_results[i]) expected_results.push_back(item_results[i]);
	endfunction

	task automatic send_item(input logic k, input logic [7:0] b);
		if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		in_ch.valid     <= 1'b1;
		in_ch.kind      <= k;
		in_ch.body_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		predict_item(k, b);
		items_sent++;
		if (k == KIND_FLUSH) flushes_sent++;
	endtask

	task automatic send_queued();
		logic [8:0] t;
		while (tx_queue.size() != 0) begin
			t = tx_queue.pop_front();
			send_item(t[8], t[7:0]);
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic value);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= value;
		@(posedge clk);
		if (idx == REG_CHUNKED_MODE) mode_chunked = value;
		else mode_raw = value;
	endtask

	task automatic set_modes(input logic chunked, input logic raw);
		settle();
		write_reg(REG_CHUNKED_MODE, chunked);
		write_reg(REG_RAW_MODE, raw);
		write_en <= 1'b0;
	endtask

	function automatic void push_byte(logic [7:0] b);
		tx_queue.push_back({KIND_BYTE, b});
	endfunction

	function automatic void push_flush();
		tx_queue.push_back({KIND_FLUSH, 8'($urandom_range(0, 255))});
	endfunction

	function automatic void push_text(string s);
		foreach (s[i]) push_byte(s[i]);
	endfunction

	function automatic logic [7:0] random_content();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic void make_line(input logic terminated);
		int style;
		int n;
		int k;
		style = $urandom_range(0, 9);
		n     = $urandom_range(0, 6);
		if (style < 5) begin
			for (int i = 0; i < 5; i++) body_q.push_back(DATA_PREFIX[39 - 8 * i -: 8]);
			if ($urandom_range(0, 1)) body_q.push_back(CH_SPACE);
		end else if (style < 7) begin
			k = $urandom_range(0, 4);
			for (int i = 0; i < k; i++) body_q.push_back(DATA_PREFIX[39 - 8 * i -: 8]);
			body_q.push_back(8'($urandom_range(int'("A"), int'("Z"))));
		end else if (style == 7) begin
			n = 0;
		end else begin
			n = $urandom_range(1, 10);
		end
		repeat (n) body_q.push_back(random_content());
		if (terminated) begin
			if ($urandom_range(0, 2) == 0) body_q.push_back(CH_CR);
			body_q.push_back(CH_LF);
		end
	endfunction

	function automatic void make_body();
		body_q.delete();
		repeat ($urandom_range(1, 4)) make_line(1'b1);
		if ($urandom_range(0, 2) == 0) make_line(1'b0);
	endfunction

	function automatic void push_hex(int unsigned v, logic upper);
		logic [3:0] nib;
		logic       started;
		started = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			nib = v[4 * i +: 4];
			if (nib != 0 || started || i == 0) begin
				started = 1'b1;
				if (nib < 10) push_byte(8'("0" + nib));
				else push_byte(8'((upper ? "A" : "a") + nib - 10));
			end
		end
	endfunction

	function automatic void push_size_line(int unsigned n);
		repeat ($urandom_range(0, 2)) push_byte(random_blank());
		if ($urandom_range(0, 3) == 0) begin
			push_byte(CH_ZERO);
			push_byte($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
		end
		if ($urandom_range(0, 3) == 0) push_byte(CH_ZERO);
		push_hex(n, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 4) == 0) push_text(";ext=1");
		if ($urandom_range(0, 3) != 0) push_byte(CH_CR);
		push_byte(CH_LF);
	endfunction

	task automatic stream_plain();
		make_body();
		foreach (body_q[i]) push_byte(body_q[i]);
		if ($urandom_range(0, 1)) push_flush();
		send_queued();
	endtask

	task automatic stream_chunked();
		int n;
		int cut;
		make_body();
		while (body_q.size() != 0) begin
			n = $urandom_range(1, 8);
			if (n > body_q.size()) n = body_q.size();
			push_size_line(n);
			repeat (n) push_byte(body_q.pop_front());
			if ($urandom_range(0, 5) == 0) push_text("zz");
			if ($urandom_range(0, 3) != 0) push_byte(CH_CR);
			push_byte(CH_LF);
		end
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: push_text("-4");
				1: push_text("fffffffffffffffffffffff");
				2: push_text("123456789abc");
				default: push_text("0x ;1");
			endcase
			push_byte(CH_CR);
			push_byte(CH_LF);
			make_body();
			foreach (body_q[i]) push_byte(body_q[i]);
		end else begin
			push_size_line(0);
			if ($urandom_range(0, 1)) push_text("x: y");
			push_byte(CH_CR);
			push_byte(CH_LF);
		end
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, tx_queue.size());
			while (tx_queue.size() > cut) void'(tx_queue.pop_back());
		end
		push_flush();
		send_queued();
	endtask

	task automatic test_event_lines();
		set_modes(1'b0, 1'b0);
		push_text("data:");
		push_byte(CH_LF);
		push_text("data: ");
		push_byte(CH_CR);
		push_byte(8'h00);
		push_byte(CH_LF);
		push_text("data:");
		push_flush();
		send_queued();
	endtask

	task automatic test_raw_lines();
		set_modes(1'b0, 1'b1);
		push_byte(CH_CR);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_flush();
		send_queued();
	endtask

	task automatic test_chunk_framing();
		set_modes(1'b1, 1'b1);
		push_byte(CH_TAB);
		push_text("0X1");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(8'h00);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_ZERO);
		push_byte(CH_LF);
		push_text("k");
		push_flush();
		send_queued();
	endtask

	task automatic test_random_streams(input int src_pct, input int sink_pct, input int n_items);
		int start;
		settle();
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		start         = items_sent;
		while (items_sent - start < n_items) begin
			case ($urandom_range(0, 4))
				0: set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				1: begin
					settle();
					write_reg(REG_RAW_MODE, !mode_raw);
					write_en <= 1'b0;
				end
				2: begin
					settle();
					write_reg(REG_CHUNKED_MODE, 1'($urandom_range(0, 1)));
					write_en <= 1'b0;
				end
				default: begin
				end
			endcase
			repeat ($urandom_range(1, 3)) begin
				if (mode_chunked == ($urandom_range(0, 6) != 0)) stream_chunked();
				else stream_plain();
			end
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.kind      = KIND_BYTE;
		in_ch.body_byte = 8'h00;
		out_ch.ready    = 1'b0;
		mode_chunked    = 1'b0;
		mode_raw        = 1'b0;
		clear_line();
		clear_framing();
		src_idle_pct  = 8;
		sink_idle_pct = 64;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_event_lines();
		test_raw_lines();
		test_chunk_framing();
		test_random_streams(8, 64, 210);
		test_random_streams(64, 8, 210);
		test_random_streams(0, 0, 210);
		settle();

		$display("Sent %0d input transactions, %0d of them end-of-stream flushes,", items_sent,
			flushes_sent);
		$display("and checked %0d results over event, raw, plain and chunked framing.",
			results_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("chunked_event_line_deframer_test: done, clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors,
				expected_results.size());
			$display("chunked_event_line_deframer_test: done, errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/celd_pkg.sv
rtl/celd_in_if.sv
rtl/celd_out_if.sv
rtl/chunked_event_line_deframer.sv
rtl/celd_checker.sv
tb/chunked_event_line_deframer_test.sv
